// ===== hw/rtl/mlfq_pkg.sv =====
`default_nettype none
package mlfq_pkg;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_CREATE = 2'd1,
    KIND_KILL   = 2'd2
  } kind_e;

  localparam logic [1:0] REG_SLICE_TOP    = 2'd0;
  localparam logic [1:0] REG_SLICE_MIDDLE = 2'd1;
  localparam logic [1:0] REG_SLICE_BOTTOM = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] level;
    logic [3:0] task_id;
  } in_word_t;

  typedef struct packed {
    logic        running_valid;
    logic [3:0]  running_slot;
    logic        switched;
    logic        op_ok;
    logic [3:0]  created_slot;
    logic [31:0] running_total;
  } out_word_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mlfq_task_scheduler_top.sv =====
// a kill of a waiting task walks its level's list through the link memory,
// one visited entry after another
// one item is in work at a time; the next word is taken no earlier than the edge
// at which the result word leaves, so a new word waits until the last is through
// reset clears active bits, list heads/tails/filled and the running slot, and sets the slices to 10, 20 and 40;
// the per-slot memories need no clearing, an entry is written before it is read
`default_nettype none
module mlfq_task_scheduler_top import mlfq_pkg::*; #(
  parameter int TASK_SLOTS = 16,
  parameter int LEVELS     = 3
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_DISP  = 12'b000000000010,
    ST_PICK  = 12'b000000000100, // read link of head for a pick
    ST_PICKW = 12'b000000001000,
    ST_TRD   = 12'b000000010000, // read running slot's record, or the victim's for a kill
    ST_TWR   = 12'b000000100000, // charge and write back on a tick; start the walk on a kill
    ST_WALK  = 12'b000001000000, // read link of cur
    ST_WALKW = 12'b000010000000,
    ST_TOTR  = 12'b000100000000, // read total of new running slot
    ST_TOTW  = 12'b001000000000,
    ST_DONE  = 12'b010000000000,
    ST_CHKP  = 12'b100000000000  // lists settled after a requeue, start the pick
  } state_e;

  // per-slot memories: one write and one read port each
  logic [LW-1:0] lvl_mem  [TASK_SLOTS];
  logic [15:0]   used_mem [TASK_SLOTS];
  logic [31:0]   tot_mem  [TASK_SLOTS];
  logic [SW-1:0] link_mem [TASK_SLOTS];

  logic [TASK_SLOTS-1:0] active_q, active_d;
  logic [SW-1:0] head_q [LEVELS];
  logic [SW-1:0] tail_q [LEVELS];
  logic [LEVELS-1:0] filled_q;
  logic [SW-1:0] run_slot_q;
  logic run_valid_q;
  logic [15:0] slice_q [3];

  state_e state_q;
  in_word_t item_q;
  logic was_valid_q;
  logic [SW-1:0] was_slot_q;
  logic ok_q;
  logic [SW-1:0] created_q;
  logic [LW-1:0] lv_q;      // level being picked or walked
  logic [SW-1:0] cur_q, prev_q;
  logic has_prev_q;
  logic [CW-1:0] cnt_q;
  logic after_pick_q;      // pick serves a tick start (then charge)
  logic out_valid_q;
  out_word_t out_q;

  // memory ports
  logic [SW-1:0] rd_addr;
  logic          rd_en;
  logic [LW-1:0] lvl_rd;
  logic [15:0]   used_rd;
  logic [31:0]   tot_rd;
  logic [SW-1:0] link_rd;
  logic lvl_we, used_we, tot_we, link_we;
  logic [SW-1:0] wr_addr, link_waddr;
  logic [LW-1:0] lvl_wd;
  logic [15:0]   used_wd;
  logic [31:0]   tot_wd;
  logic [SW-1:0] link_wd;

  always_ff @(posedge clk_i) begin
    if (lvl_we) lvl_mem[wr_addr] <= lvl_wd;
    if (used_we) used_mem[wr_addr] <= used_wd;
    if (tot_we) tot_mem[wr_addr] <= tot_wd;
    if (link_we) link_mem[link_waddr] <= link_wd;
    if (rd_en) begin
      lvl_rd  <= lvl_mem[rd_addr];
      used_rd <= used_mem[rd_addr];
      tot_rd  <= tot_mem[rd_addr];
      link_rd <= link_mem[rd_addr];
    end
  end

  // highest non-empty level
  logic any_filled;
  logic [LW-1:0] top_lv;
  always_comb begin
    any_filled = 1'b0;
    top_lv = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (filled_q[l]) begin
        any_filled = 1'b1;
        top_lv = LW'(l);
      end
    end
  end

  // lowest free slot
  logic free_found;
  logic [SW-1:0] free_slot;
  always_comb begin
    free_found = 1'b0;
    free_slot = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_slot = SW'(i);
      end
    end
  end

  // create level saturated
  logic [LW-1:0] cr_lv;
  assign cr_lv = (32'(item_q.level) < LEVELS) ? LW'(item_q.level) : LW'(LEVELS - 1);

  // tick charge
  logic [15:0] used_inc, slice_sel;
  logic slice_done, higher_wait;
  logic [LW-1:0] new_lv;
  always_comb begin
    used_inc = used_rd + 16'd1;
    case (lvl_rd)
      LW'(0): slice_sel = slice_q[0];
      LW'(1): slice_sel = slice_q[1];
      default: slice_sel = slice_q[2];
    endcase
    slice_done = used_inc >= slice_sel;
    new_lv = (32'(lvl_rd) + 1 < LEVELS) ? lvl_rd + LW'(1) : lvl_rd;
    higher_wait = 1'b0;
    for (int p = 0; p < LEVELS; p++)
      if (LW'(p) < lvl_rd && filled_q[p]) higher_wait = 1'b1;
  end

  logic [SW-1:0] kill_id;
  logic kill_hit;
  assign kill_id = SW'(item_q.task_id);
  assign kill_hit = (32'(item_q.task_id) < TASK_SLOTS) && active_q[kill_id];

  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      active_q <= '0;
      filled_q <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
      end
      run_slot_q <= '0;
      run_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      slice_q[0] <= 16'd10;
      slice_q[1] <= 16'd20;
      slice_q[2] <= 16'd40;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_SLICE_TOP:    slice_q[0] <= pwdata[15:0];
          REG_SLICE_MIDDLE: slice_q[1] <= pwdata[15:0];
          REG_SLICE_BOTTOM: slice_q[2] <= pwdata[15:0];
          default: ;
        endcase
      end
      // result word raised from the done state, dropped once taken
      if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      active_q <= active_d;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            item_q <= in_word_i;
            was_valid_q <= run_valid_q;
            was_slot_q <= run_slot_q;
            ok_q <= 1'b0;
            created_q <= '0;
            state_q <= ST_DISP;
          end
        end
        ST_DISP: begin
          case (item_q.kind)
            KIND_TICK: begin
              if (run_valid_q) state_q <= ST_TRD;
              else if (any_filled) begin
                after_pick_q <= 1'b1;
                lv_q <= top_lv;
                state_q <= ST_PICK;
              end else state_q <= ST_TOTR;
            end
            KIND_CREATE: begin
              if (free_found) begin
                ok_q <= 1'b1;
                created_q <= free_slot;
                if (!filled_q[cr_lv]) begin
                  head_q[cr_lv] <= free_slot;
                  filled_q[cr_lv] <= 1'b1;
                end
                tail_q[cr_lv] <= free_slot;
              end
              state_q <= ST_TOTR;
            end
            KIND_KILL: begin
              if (kill_hit) begin
                ok_q <= 1'b1;
                if (run_valid_q && run_slot_q == kill_id) begin
                  if (any_filled) begin
                    after_pick_q <= 1'b0;
                    lv_q <= top_lv;
                    state_q <= ST_PICK;
                  end else begin
                    run_valid_q <= 1'b0;
                    run_slot_q <= '0;
                    state_q <= ST_TOTR;
                  end
                end else state_q <= ST_TRD; // read victim's level first
              end else state_q <= ST_TOTR;
            end
            default: state_q <= ST_TOTR;
          endcase
        end
        ST_PICK: state_q <= ST_PICKW;
        ST_PICKW: begin
          if (head_q[lv_q] == tail_q[lv_q]) filled_q[lv_q] <= 1'b0;
          else head_q[lv_q] <= link_rd;
          run_slot_q <= head_q[lv_q];
          run_valid_q <= 1'b1;
          if (after_pick_q) begin
            after_pick_q <= 1'b0;
            state_q <= ST_TRD;
          end else state_q <= ST_TOTR;
        end
        ST_TRD: state_q <= ST_TWR;
        ST_TWR: begin
          if (item_q.kind == KIND_TICK) begin
            if (slice_done || higher_wait) begin
              // push to the (new) level then pick; the list may become this task
              if (!filled_q[slice_done ? new_lv : lvl_rd]) begin
                head_q[slice_done ? new_lv : lvl_rd] <= run_slot_q;
                filled_q[slice_done ? new_lv : lvl_rd] <= 1'b1;
              end
              tail_q[slice_done ? new_lv : lvl_rd] <= run_slot_q;
              state_q <= ST_CHKP;
            end else state_q <= ST_TOTR;
          end else begin
            // kill of a waiting task: walk its level
            lv_q <= lvl_rd;
            if (!filled_q[lvl_rd]) state_q <= ST_TOTR;
            else begin
              cur_q <= head_q[lvl_rd];
              has_prev_q <= 1'b0;
              cnt_q <= '0;
              state_q <= ST_WALK;
            end
          end
        end
        ST_CHKP: begin
          after_pick_q <= 1'b0;
          lv_q <= top_lv;
          state_q <= ST_PICK;
        end
        ST_WALK: state_q <= ST_WALKW;
        ST_WALKW: begin
          if (cur_q == kill_id) begin
            if (!has_prev_q) begin
              if (cur_q == tail_q[lv_q]) filled_q[lv_q] <= 1'b0;
              else head_q[lv_q] <= link_rd;
            end else if (tail_q[lv_q] == cur_q) tail_q[lv_q] <= prev_q;
            state_q <= ST_TOTR;
          end else if (cur_q == tail_q[lv_q] || cnt_q == CW'(TASK_SLOTS - 1)) begin
            state_q <= ST_TOTR;
          end else begin
            prev_q <= cur_q;
            has_prev_q <= 1'b1;
            cur_q <= link_rd;
            cnt_q <= cnt_q + CW'(1);
            state_q <= ST_WALK;
          end
        end
        ST_TOTR: state_q <= ST_TOTW;
        ST_TOTW: begin
          out_q.running_valid <= run_valid_q;
          out_q.running_slot <= run_valid_q ? 4'(run_slot_q) : 4'd0;
          out_q.switched <= (was_valid_q != run_valid_q) ||
                            (run_valid_q && was_slot_q != run_slot_q);
          out_q.op_ok <= ok_q;
          out_q.created_slot <= 4'(created_q);
          out_q.running_total <= run_valid_q ? tot_rd : 32'd0;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // active bits and memory control
  always_comb begin
    active_d = active_q;
    rd_en = 1'b0;
    rd_addr = run_slot_q;
    lvl_we = 1'b0; used_we = 1'b0; tot_we = 1'b0; link_we = 1'b0;
    wr_addr = run_slot_q;
    link_waddr = run_slot_q;
    lvl_wd = lvl_rd; used_wd = used_inc; tot_wd = tot_rd + 32'd1;
    link_wd = run_slot_q;
    case (state_q)
      ST_DISP: begin
        if (item_q.kind == KIND_CREATE && free_found) begin
          active_d[free_slot] = 1'b1;
          wr_addr = free_slot;
          lvl_we = 1'b1; used_we = 1'b1; tot_we = 1'b1;
          lvl_wd = cr_lv; used_wd = '0; tot_wd = '0;
          if (filled_q[cr_lv]) begin
            link_we = 1'b1;
            link_waddr = tail_q[cr_lv];
            link_wd = free_slot;
          end
        end
        if (item_q.kind == KIND_KILL && kill_hit) active_d[kill_id] = 1'b0;
      end
      ST_PICK: begin
        rd_en = 1'b1;
        rd_addr = head_q[lv_q];
      end
      ST_TRD: begin
        rd_en = 1'b1;
        rd_addr = (item_q.kind == KIND_TICK) ? run_slot_q : kill_id;
      end
      ST_TWR: begin
        if (item_q.kind == KIND_TICK) begin
          tot_we = 1'b1;
          used_we = 1'b1;
          if (slice_done) begin
            used_wd = '0;
            lvl_we = 1'b1;
            lvl_wd = new_lv;
          end
          if ((slice_done || higher_wait) && filled_q[slice_done ? new_lv : lvl_rd]) begin
            link_we = 1'b1;
            link_waddr = tail_q[slice_done ? new_lv : lvl_rd];
            link_wd = run_slot_q;
          end
        end
      end
      ST_WALK: begin
        rd_en = 1'b1;
        rd_addr = cur_q;
      end
      ST_WALKW: begin
        if (cur_q == kill_id && has_prev_q) begin
          link_we = 1'b1;
          link_waddr = prev_q;
          link_wd = link_rd;
        end
      end
      ST_TOTR: begin
        rd_en = 1'b1;
        rd_addr = run_slot_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o = out_q;
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_SLICE_TOP:    prdata = {16'd0, slice_q[0]};
      REG_SLICE_MIDDLE: prdata = {16'd0, slice_q[1]};
      REG_SLICE_BOTTOM: prdata = {16'd0, slice_q[2]};
      default:          prdata = 32'd0;
    endcase
  end

  // in the idle state a running slot is always an active task
  a_run_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && run_valid_q) |-> active_q[run_slot_q])
    else $error("running slot not active");
  // no word is taken while one is in work
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input taken during work");
  // result only leaves from the done state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside done");
endmodule
`default_nettype wire
